[rtl/modem_sleep_wake_sequencer_assert.svh]
// ============================================================================
// Modem sleep/wake sequencer - assertion macros
// Shared property shapes for the sequencer checks; clk and rst_n in scope.
// ============================================================================
`ifndef MODEM_SLEEP_WAKE_SEQUENCER_ASSERT_SVH
`define MODEM_SLEEP_WAKE_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define MSWS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed (same cycle)");

// Next-cycle implication
`define MSWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed (next cycle)");

`endif

[rtl/msws_pkg.sv]
// ============================================================================
// msws_pkg
// Types, codes and reset values for the modem sleep/wake sequencer.
// ============================================================================
package msws_pkg;

    // Field widths
    localparam int unsigned DEP_W   = 4;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned IDX_W   = 3;

    // Default number of dependent slots
    localparam int unsigned DEPEND_SLOTS_DEF = 4;

    // Event kinds carried on the input tuser
    typedef enum logic [1:0] {
        EV_WAKE  = 2'd0,
        EV_SLEEP = 2'd1,
        EV_TICK  = 2'd2,
        EV_RESP  = 2'd3
    } event_t;

    // Response status codes
    localparam logic [1:0] RESP_NONE    = 2'd0;
    localparam logic [1:0] RESP_NOMATCH = 2'd1;
    localparam logic [1:0] RESP_DONE    = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_DEP_MASK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEP_WAIT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STOP_WAIT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RETRY_WAIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESP_WAIT  = 3'd4;

    // Reset values, assuming a 10 ms tick
    localparam logic [DEP_W-1:0]  RST_DEP_MASK   = 4'd0;
    localparam logic [TICK_W-1:0] RST_DEP_WAIT   = 16'd1000;
    localparam logic [TICK_W-1:0] RST_STOP_WAIT  = 16'd1000;
    localparam logic [TICK_W-1:0] RST_RETRY_WAIT = 16'd100;
    localparam logic [TICK_W-1:0] RST_RESP_WAIT  = 16'd1500;

    // Action strobes of one result
    typedef struct packed {
        logic notify_awake;
        logic notify_asleep;
        logic reinit_stack;
        logic host_wake;
        logic host_sleep;
        logic send_wake_cmd;
        logic send_sleep_cmd;
        logic try_sleep_seq;
        logic abort_and_stop;
    } strobe_t;

endpackage

[rtl/modem_sleep_wake_sequencer.sv]
// ============================================================================
// modem_sleep_wake_sequencer
// Ten-state modem sleep/wake sequencer with a saturating tick countdown.
// ============================================================================
// Usage:
//   s_* channel: one event request per beat. s_tuser is the event kind
//   (wake, sleep, tick, sleep-command response); s_tdata carries the status
//   inputs sampled with it. m_* channel: exactly one result per event with
//   the new state, action strobes, response status and countdown value.
//   cfg_* channel: register writes by index, taken at any time (always
//   ready); write only while no event is in flight.
// Decode and throughput:
//   An event is decoded in the cycle it is taken, against the state and
//   countdown registers; its result is registered onto m_* in the next
//   cycle. One event per cycle unless m_* stalls (single state/count loop).
// Reset:
//   rst_n clears state to idle, countdown to zero, config to defaults and
//   drops m_tvalid.
// Stall:
//   While m_tvalid is high and m_tready low, s_tready is low and the
//   result register holds; a result taken frees the slot in the same cycle.
// ============================================================================
module modem_sleep_wake_sequencer #(
    parameter int unsigned DEPEND_SLOTS = msws_pkg::DEPEND_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Event input
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] depend_ready, [4] stop_finished, [5] post_action_sleep,
    // [6] seq_accepted, [7] resp_is_sleep_cmd
    input  logic [7:0]  s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] new_state, [4] abort_and_stop, [5] try_sleep_seq,
    // [6] send_sleep_cmd, [7] send_wake_cmd, [8] host_sleep, [9] host_wake,
    // [10] reinit_stack, [11] notify_asleep, [12] notify_awake,
    // [14:13] resp_status, [30:15] ticks_left, [31] zero
    output logic [31:0] m_tdata,
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    `include "modem_sleep_wake_sequencer_assert.svh"

    typedef enum logic [msws_pkg::STATE_W-1:0] {
        ST_IDLE       = 4'd0,
        ST_WAITDEP    = 4'd1,
        ST_STOP       = 4'd2,
        ST_DOSLEEP    = 4'd3,
        ST_WAITRESP   = 4'd4,
        ST_SLEEP      = 4'd5,
        ST_WAITDEP_W  = 4'd6,
        ST_STOP_W     = 4'd7,
        ST_DOSLEEP_W  = 4'd8,
        ST_WAITRESP_W = 4'd9
    } state_t;

    // Configuration registers
    logic [msws_pkg::DEP_W-1:0]  dep_mask_reg;
    logic [msws_pkg::TICK_W-1:0] dep_wait_reg;
    logic [msws_pkg::TICK_W-1:0] stop_wait_reg;
    logic [msws_pkg::TICK_W-1:0] retry_wait_reg;
    logic [msws_pkg::TICK_W-1:0] resp_wait_reg;

    // Sequencer state and result register
    state_t                      state_reg, state_next;
    logic [msws_pkg::TICK_W-1:0] count_reg, count_next;
    logic                        out_valid_reg;
    msws_pkg::strobe_t           strobe_reg, strobe_next;
    logic [1:0]                  resp_reg, resp_next;

    // Decoded input fields
    msws_pkg::event_t            ev;
    logic [msws_pkg::DEP_W-1:0]  dep_ready;
    logic                        stop_done;
    logic                        post_sleep;
    logic                        seq_ok;
    logic                        is_sleep_cmd;

    logic [msws_pkg::DEP_W-1:0]  slot_mask;
    logic [msws_pkg::TICK_W-1:0] count_dec;
    logic                        all_ready;
    logic                        in_acc;

    assign ev           = msws_pkg::event_t'(s_tuser);
    assign dep_ready    = s_tdata[3:0];
    assign stop_done    = s_tdata[4];
    assign post_sleep   = s_tdata[5];
    assign seq_ok       = s_tdata[6];
    assign is_sleep_cmd = s_tdata[7];

    // Handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, count_reg, resp_reg, strobe_reg, state_reg};

    // Slots at or above DEPEND_SLOTS are ignored
    always_comb
    begin
        for (int i = 0; i < msws_pkg::DEP_W; i++)
        begin
            slot_mask[i] = (i < DEPEND_SLOTS);
        end
    end

    // Saturating countdown step and dependent readiness
    assign count_dec = (count_reg == '0) ? '0 : count_reg - 16'd1;
    assign all_ready = ((dep_mask_reg & ~dep_ready & slot_mask) == '0);

    // Event decode
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        strobe_next = '0;
        resp_next   = msws_pkg::RESP_NONE;
        case (ev)
            msws_pkg::EV_WAKE:
            begin
                case (state_reg)
                    ST_WAITDEP:
                    begin
                        count_next = '0;
                        state_next = ST_WAITDEP_W;
                    end
                    ST_STOP:     state_next = ST_STOP_W;
                    ST_DOSLEEP:
                    begin
                        count_next = '0;
                        state_next = ST_DOSLEEP_W;
                    end
                    ST_WAITRESP: state_next = ST_WAITRESP_W;
                    ST_SLEEP:
                    begin
                        strobe_next.host_wake     = 1'b1;
                        strobe_next.notify_awake  = 1'b1;
                        strobe_next.send_wake_cmd = 1'b1;
                        state_next                = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            msws_pkg::EV_SLEEP:
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        count_next = dep_wait_reg;
                        state_next = ST_WAITDEP;
                    end
                    ST_WAITDEP_W:  state_next = ST_WAITDEP;
                    ST_STOP_W:     state_next = ST_STOP;
                    ST_DOSLEEP_W:  state_next = ST_DOSLEEP;
                    ST_WAITRESP_W: state_next = ST_WAITRESP;
                    default: ;
                endcase
            end
            msws_pkg::EV_TICK:
            begin
                case (state_reg)
                    ST_WAITDEP:
                    begin
                        count_next = count_dec;
                        if (all_ready || count_dec == '0)
                        begin
                            strobe_next.abort_and_stop = 1'b1;
                            count_next                 = stop_wait_reg;
                            state_next                 = ST_STOP;
                        end
                    end
                    ST_STOP:
                    begin
                        count_next = count_dec;
                        if (stop_done || count_dec == '0)
                        begin
                            if (post_sleep)
                            begin
                                strobe_next.try_sleep_seq = 1'b1;
                                if (seq_ok)
                                    state_next = ST_DOSLEEP;
                                else
                                    count_next = retry_wait_reg;
                            end
                            else
                            begin
                                strobe_next.reinit_stack  = 1'b1;
                                strobe_next.notify_asleep = 1'b1;
                                state_next                = ST_SLEEP;
                            end
                        end
                    end
                    ST_DOSLEEP:
                    begin
                        strobe_next.send_sleep_cmd = 1'b1;
                        count_next                 = resp_wait_reg;
                        state_next                 = ST_WAITRESP;
                    end
                    ST_WAITRESP:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            strobe_next.reinit_stack  = 1'b1;
                            strobe_next.notify_asleep = 1'b1;
                            strobe_next.host_sleep    = 1'b1;
                            state_next                = ST_SLEEP;
                        end
                    end
                    ST_WAITDEP_W:
                    begin
                        strobe_next.host_wake = 1'b1;
                        count_next            = '0;
                        state_next            = ST_IDLE;
                    end
                    ST_STOP_W:
                    begin
                        count_next = count_dec;
                        if (stop_done || count_dec == '0)
                        begin
                            strobe_next.host_wake    = 1'b1;
                            strobe_next.notify_awake = 1'b1;
                            state_next               = ST_IDLE;
                        end
                    end
                    ST_DOSLEEP_W:
                    begin
                        strobe_next.host_wake    = 1'b1;
                        strobe_next.notify_awake = 1'b1;
                        state_next               = ST_IDLE;
                    end
                    ST_WAITRESP_W:
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            strobe_next.host_wake     = 1'b1;
                            strobe_next.send_wake_cmd = 1'b1;
                            strobe_next.notify_awake  = 1'b1;
                            state_next                = ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            msws_pkg::EV_RESP:
            begin
                if (!is_sleep_cmd)
                begin
                    resp_next = msws_pkg::RESP_NOMATCH;
                end
                else
                begin
                    resp_next = msws_pkg::RESP_DONE;
                    if (state_reg == ST_WAITRESP)
                    begin
                        strobe_next.notify_asleep = 1'b1;
                        strobe_next.host_sleep    = 1'b1;
                        state_next                = ST_SLEEP;
                    end
                    else
                    begin
                        // late response outside the wait: treat as a wake
                        strobe_next.host_wake     = 1'b1;
                        strobe_next.send_wake_cmd = 1'b1;
                        strobe_next.notify_awake  = 1'b1;
                        state_next                = ST_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // State, countdown and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            strobe_reg    <= '0;
            resp_reg      <= msws_pkg::RESP_NONE;
        end
        else
        begin
            if (in_acc)
            begin
                state_reg     <= state_next;
                count_reg     <= count_next;
                strobe_reg    <= strobe_next;
                resp_reg      <= resp_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dep_mask_reg   <= msws_pkg::RST_DEP_MASK;
            dep_wait_reg   <= msws_pkg::RST_DEP_WAIT;
            stop_wait_reg  <= msws_pkg::RST_STOP_WAIT;
            retry_wait_reg <= msws_pkg::RST_RETRY_WAIT;
            resp_wait_reg  <= msws_pkg::RST_RESP_WAIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                msws_pkg::REG_DEP_MASK:   dep_mask_reg   <= cfg_data[msws_pkg::DEP_W-1:0];
                msws_pkg::REG_DEP_WAIT:   dep_wait_reg   <= cfg_data;
                msws_pkg::REG_STOP_WAIT:  stop_wait_reg  <= cfg_data;
                msws_pkg::REG_RETRY_WAIT: retry_wait_reg <= cfg_data;
                msws_pkg::REG_RESP_WAIT:  resp_wait_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Checks
    `MSWS_ASSERT_NEXT(a_count_holds_idle, !in_acc, $stable(count_reg) && $stable(state_reg))
    `MSWS_ASSERT_NEXT(a_state_reported, in_acc, m_tvalid && m_tdata[3:0] == state_reg)
    `MSWS_ASSERT_NEXT(a_ticks_reported, in_acc, m_tdata[30:15] == count_reg)
    `MSWS_ASSERT_NOW(a_notify_exclusive, m_tvalid, !(m_tdata[11] && m_tdata[12]))

endmodule
